[sv/gta_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_pkg
// Shared constants and control types for the generation tagged array.
// ----------------------------------------------------------------------------
package gta_pkg;

    // Default sizes of the array
    localparam int DEPTH_DFLT     = 1024;
    localparam int DATA_BITS_DFLT = 32;
    localparam int GEN_BITS_DFLT  = 16;

    // Port field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 32;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_GET   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // take the input transaction this cycle
        logic sweep;     // write a zero tag at the sweep address and advance
        logic load_out;  // load the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic wrap_clear;  // input is a clear while the generation is at its top
        logic sweep_last;  // sweep address is on the last entry
    } t_sts;

endpackage
`default_nettype wire

[sv/gta_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_in_if
// Operation channel: opcode, index and value with valid/ready.
// ----------------------------------------------------------------------------
interface gta_in_if;
    logic                             valid;
    logic                             ready;
    logic [gta_pkg::OPCODE_W-1:0]     opcode;
    logic [gta_pkg::INDEX_W-1:0]      index;
    logic [gta_pkg::VALUE_W-1:0]      value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface
`default_nettype wire

[sv/gta_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_out_if
// Result channel: read value and current flag with valid/ready.
// ----------------------------------------------------------------------------
interface gta_out_if;
    logic                         valid;
    logic                         ready;
    logic [gta_pkg::VALUE_W-1:0]  read_value;
    logic                         was_current;

    modport source (output valid, output read_value, output was_current, input ready);
    modport sink   (input valid, input read_value, input was_current, output ready);
endinterface
`default_nettype wire

[sv/gta_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_cfg_if
// Configuration write channel for the default value register.
// ----------------------------------------------------------------------------
interface gta_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [gta_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/gta_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_ctrl
// Sequencer: accepts a transaction, runs the execute cycle or the tag sweep,
// and issues the result load.
// ----------------------------------------------------------------------------
module gta_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gta_pkg::t_sts i_sts,
    output gta_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_wrap, n_wrap;
    logic   accept;

    // Accept only when idle and the output register is free
    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = o_in_ready && i_in_valid;

    // Commands
    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.sweep    = (r_state == S_SWEEP);
        o_cmd.load_out = (r_state == S_EXEC);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_wrap  = r_wrap;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.wrap_clear) begin
                        n_state = S_SWEEP;
                        n_wrap  = 1'b1;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = r_wrap ? S_EXEC : S_IDLE;
                    n_wrap  = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; reset starts with a full tag sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_wrap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wrap  <= n_wrap;
        end
    end

endmodule
`default_nettype wire

[sv/gta_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gta_dpath
// Value and tag memories, generation counter, sweep address, default
// register and output register.
// ----------------------------------------------------------------------------
module gta_dpath #(
    parameter int DEPTH     = gta_pkg::DEPTH_DFLT,
    parameter int DATA_BITS = gta_pkg::DATA_BITS_DFLT,
    parameter int GEN_BITS  = gta_pkg::GEN_BITS_DFLT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gta_pkg::t_cmd                 i_cmd,
    output gta_pkg::t_sts                      o_sts,
    input  wire logic [gta_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [gta_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [gta_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_cfg_wr,
    input  wire logic [gta_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [gta_pkg::VALUE_W-1:0]        o_read_value,
    output logic                               o_was_current
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0]       LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [GEN_BITS-1:0] GEN_ONE   = GEN_BITS'(1);
    localparam logic [GEN_BITS-1:0] GEN_TOP   = {GEN_BITS{1'b1}};

    logic [DATA_BITS-1:0] mem_value [DEPTH];
    logic [GEN_BITS-1:0]  mem_tag   [DEPTH];

    logic [31:0]                  idx_ext;
    logic [AW-1:0]                addr;
    logic                         in_range;
    logic                         hit;

    logic [GEN_BITS-1:0]          r_gen;
    logic [AW-1:0]                r_cnt;
    logic [DATA_BITS-1:0]         r_default;
    logic [gta_pkg::OPCODE_W-1:0] r_op;
    logic                         r_in_range;
    logic [DATA_BITS-1:0]         r_val_rd;
    logic [GEN_BITS-1:0]          r_tag_rd;
    logic                         r_out_valid;
    logic [gta_pkg::VALUE_W-1:0]  r_read_value;
    logic                         r_was_current;

    // Decode address and range
    assign idx_ext  = 32'(i_index);
    assign addr     = idx_ext[AW-1:0];
    assign in_range = idx_ext < 32'(DEPTH);

    // Status
    always_comb begin
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.wrap_clear = (i_opcode == gta_pkg::OP_CLEAR) && (r_gen == GEN_TOP);
        o_sts.sweep_last = (r_cnt == LAST_ADDR);
    end

    // Value memory: write on set, read on every accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_opcode == gta_pkg::OP_SET) && in_range) begin
            mem_value[addr] <= DATA_BITS'(i_value);
        end
        if (i_cmd.accept) begin
            r_val_rd <= mem_value[addr];
        end
    end

    // Tag memory: zero during sweep, stamp on set, read on every accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            mem_tag[r_cnt] <= '0;
        end else if (i_cmd.accept && (i_opcode == gta_pkg::OP_SET) && in_range) begin
            mem_tag[addr] <= r_gen;
        end
        if (i_cmd.accept) begin
            r_tag_rd <= mem_tag[addr];
        end
    end

    // Latch the operation for the execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_opcode;
            r_in_range <= in_range;
        end
    end

    // Advance generation on clear; restart at one on wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_ONE;
        end else if (i_cmd.accept && (i_opcode == gta_pkg::OP_CLEAR)) begin
            r_gen <= (r_gen == GEN_TOP) ? GEN_ONE : r_gen + GEN_ONE;
        end
    end

    // Sweep address; returns to zero after the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt <= (r_cnt == LAST_ADDR) ? '0 : r_cnt + AW'(1);
        end
    end

    // Default value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (i_cfg_wr) begin
            r_default <= DATA_BITS'(i_cfg_data);
        end
    end

    // Compare tag against the current generation
    assign hit = (r_op == gta_pkg::OP_GET) && r_in_range && (r_tag_rd == r_gen);

    // Output register; hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_was_current <= hit;
            if (hit) begin
                r_read_value <= gta_pkg::VALUE_W'(r_val_rd);
            end else if (r_op == gta_pkg::OP_GET) begin
                r_read_value <= gta_pkg::VALUE_W'(r_default);
            end else begin
                r_read_value <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_was_current = r_was_current;

endmodule
`default_nettype wire

[sv/generation_tagged_array.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// generation_tagged_array
// Word array with a constant time clear by generation tags.
//
// Channels: i_in carries operations (get, set, clear) with an index and a
// value; o_out returns one result transaction per operation (read value and
// a flag that the entry was written since the last clear); i_cfg writes the
// default value returned for stale or unwritten entries, and is always ready.
// An accepted operation reads the value and tag memories into registers; the
// tag compare then loads the output register in the execute state, and a new
// operation is taken only after that execute state.
// A clear while the generation counter is at its top value zeroes all tags
// at one entry per cycle before its result appears.
// Reset: the same tag sweep runs first with i_in not ready; generation
// restarts at one and the default value at zero.
// Stall: a result waits in the output register while o_out.ready is low;
// a new operation is taken only when that register is empty or being taken.
// ----------------------------------------------------------------------------
module generation_tagged_array #(
    parameter int DEPTH     = gta_pkg::DEPTH_DFLT,
    parameter int DATA_BITS = gta_pkg::DATA_BITS_DFLT,
    parameter int GEN_BITS  = gta_pkg::GEN_BITS_DFLT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gta_in_if.sink      i_in,
    gta_out_if.source   o_out,
    gta_cfg_if.sink     i_cfg
);

    gta_pkg::t_cmd cmd;
    gta_pkg::t_sts sts;
    logic          in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    gta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gta_dpath #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS),
        .GEN_BITS  (GEN_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_in.opcode),
        .i_index       (i_in.index),
        .i_value       (i_in.value),
        .i_cfg_wr      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_read_value  (o_out.read_value),
        .o_was_current (o_out.was_current)
    );

endmodule
`default_nettype wire

[verif/generation_tagged_array_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_tagged_array_checker
// Watches the operation, result and default value channels of the
// generation tagged array, keeps its own copy of the word array, stamps and
// generation, and compares every result transaction with the lookup it
// predicted for the oldest outstanding operation.
// ----------------------------------------------------------------------------
module generation_tagged_array_checker
    import gta_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gta_in_if          i_in,
    gta_out_if         i_out,
    gta_cfg_if         i_cfg,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               was_current;
    } t_lookup;

    // Shadow copy of the array state
    logic [DATA_BITS_DFLT-1:0] word_mem  [DEPTH_DFLT];
    logic [GEN_BITS_DFLT-1:0]  stamp_mem [DEPTH_DFLT];
    logic [GEN_BITS_DFLT-1:0]  generation;
    logic [CFG_W-1:0]          default_word;

    t_lookup lookups_due [$];
    int      fails = 0;

    assign o_fail_count = fails;

    // Count a failure; print only the first few
    task automatic note_failure(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("[%0t] checker: %s", $realtime, msg);
        end
    endtask

    // Apply one operation to the shadow state and return its lookup result
    function automatic t_lookup apply_operation(input logic [OPCODE_W-1:0] op,
                                                input logic [INDEX_W-1:0]  idx,
                                                input logic [VALUE_W-1:0]  val);
        t_lookup res;
        bit      in_range;
        res      = '0;
        in_range = int'(idx) < DEPTH_DFLT;
        case (op)
            OP_GET: begin
                res.read_value = default_word;
                if (in_range && stamp_mem[idx] == generation) begin
                    res.read_value = word_mem[idx];
                    res.was_current = 1'b1;
                end
            end
            OP_SET: begin
                if (in_range) begin
                    word_mem[idx]  = val;
                    stamp_mem[idx] = generation;
                end
            end
            OP_CLEAR: begin
                // Wrap: zero every stamp and restart at one
                if (generation == '1) begin
                    foreach (stamp_mem[k]) stamp_mem[k] = '0;
                    generation = GEN_BITS_DFLT'(1);
                end else begin
                    generation = generation + 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_lookup seen;
        t_lookup due;
        if (!i_rst_n) begin
            foreach (word_mem[k]) word_mem[k] = '0;
            foreach (stamp_mem[k]) stamp_mem[k] = '0;
            generation   = GEN_BITS_DFLT'(1);
            default_word = '0;
            lookups_due.delete();
        end else begin
            // Compare the result transaction with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                seen.read_value  = i_out.read_value;
                seen.was_current = i_out.was_current;
                if (lookups_due.size() == 0) begin
                    note_failure($sformatf("unexpected result read_value=%h was_current=%b",
                                           seen.read_value, seen.was_current));
                end else begin
                    due = lookups_due.pop_front();
                    if (seen.read_value !== due.read_value) begin
                        note_failure($sformatf("read_value expected %h got %h",
                                               due.read_value, seen.read_value));
                    end
                    if (seen.was_current !== due.was_current) begin
                        note_failure($sformatf("was_current expected %b got %b",
                                               due.was_current, seen.was_current));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                default_word = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                lookups_due.push_back(apply_operation(i_in.opcode, i_in.index, i_in.value));
            end
        end
        o_pending <= lookups_due.size();
    end

endmodule

[verif/generation_tagged_array_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_tagged_array_tb
// Drives get, set and clear transactions into the generation tagged array in
// random bursts while the result side stalls on its own pattern. A directed
// pass over field extremes, stale and fresh entries across clears comes
// first, then random segments under several default values follow.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module generation_tagged_array_tb;
    import gta_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 8000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SEGMENTS      = 5;
    localparam int SEGMENT_ITEMS = 203;
    localparam int HOT_INDICES   = 16;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;

    // Stimulus bookkeeping
    int                       burst_left = 0;
    bit                       hold_req   = 1'b0;

    gta_in_if  in_ch ();
    gta_out_if out_ch ();
    gta_cfg_if cfg_ch ();

    generation_tagged_array i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    generation_tagged_array_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // Offer one operation; open a new burst with a random gap when due
    task automatic offer(input logic [OPCODE_W-1:0] op,
                         input logic [INDEX_W-1:0]  idx,
                         input logic [VALUE_W-1:0]  val);
        int          gap;
        logic [31:0] junk;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                junk = $urandom;
                in_ch.valid  <= 1'b0;
                in_ch.opcode <= junk[1:0];
                in_ch.index  <= junk[11:2];
                in_ch.value  <= $urandom;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.index  <= idx;
        in_ch.value  <= val;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the default value register
    task automatic write_default(input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random operation, biased to a small hot set of entries
    task automatic pick_random(output logic [OPCODE_W-1:0] op,
                               output logic [INDEX_W-1:0]  idx,
                               output logic [VALUE_W-1:0]  val);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      op = OP_GET;
        else if (roll < 85) op = OP_SET;
        else if (roll < 95) op = OP_CLEAR;
        else                op = OP_UNUSED;
        roll = $urandom_range(0, 9);
        if (roll < 6)      idx = INDEX_W'($urandom_range(0, HOT_INDICES - 1));
        else if (roll < 7) idx = '0;
        else if (roll < 8) idx = INDEX_W'(DEPTH_DFLT - 1);
        else               idx = INDEX_W'($urandom_range(0, DEPTH_DFLT - 1));
        roll = $urandom_range(0, 15);
        if (roll == 0)      val = '0;
        else if (roll == 1) val = '1;
        else                val = $urandom;
    endtask

    // Result side: stall pattern, with a long hold-off on request
    initial begin : result_side
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Abort when no transaction moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("generation_tagged_array_tb NOT OK");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        logic [CFG_W-1:0]    dflt;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_GET;
        in_ch.index  <= '0;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_default('1);

        // Directed: field extremes, every operation, unused opcode
        offer(OP_GET,    '0,                      '0);
        offer(OP_GET,    INDEX_W'(DEPTH_DFLT - 1), '1);
        offer(OP_GET,    INDEX_W'(512),           '0);
        offer(OP_UNUSED, INDEX_W'(DEPTH_DFLT - 1), '1);
        offer(OP_UNUSED, '0,                      '0);
        offer(OP_GET,    INDEX_W'(DEPTH_DFLT - 1), '0);
        offer(OP_CLEAR,  INDEX_W'(DEPTH_DFLT - 1), '1);
        offer(OP_GET,    '0,                      '0);
        offer(OP_GET,    INDEX_W'(DEPTH_DFLT - 1), '0);
        offer(OP_SET,    '0,                      '1);
        offer(OP_GET,    '0,                      '0);
        offer(OP_SET,    INDEX_W'(DEPTH_DFLT - 1), '0);
        offer(OP_GET,    INDEX_W'(DEPTH_DFLT - 1), '1);
        offer(OP_GET,    INDEX_W'(1),             '0);
        offer(OP_CLEAR,  '0,                      '0);
        offer(OP_CLEAR,  '1,                      '1);
        offer(OP_GET,    '0,                      '0);
        offer(OP_SET,    '0,                      '0);
        offer(OP_GET,    '0,                      '1);
        drain();
        write_default('0);
        offer(OP_GET,    INDEX_W'(1),             '0);
        offer(OP_SET,    INDEX_W'(2),             32'h1234_5678);
        offer(OP_GET,    INDEX_W'(2),             '0);
        offer(OP_CLEAR,  INDEX_W'(2),             '0);
        offer(OP_GET,    INDEX_W'(2),             '0);
        drain();

        // Stale and fresh entries across a few clears
        write_default($urandom);
        offer(OP_SET,   INDEX_W'(5),              $urandom);
        offer(OP_CLEAR, '0,                       '0);
        offer(OP_SET,   INDEX_W'(7),              $urandom);
        offer(OP_SET,   INDEX_W'(DEPTH_DFLT - 1), $urandom);
        offer(OP_GET,   INDEX_W'(5),              '0);
        offer(OP_GET,   INDEX_W'(7),              '0);
        offer(OP_CLEAR, '0,                       '0);
        offer(OP_GET,   INDEX_W'(7),              '0);
        offer(OP_GET,   INDEX_W'(DEPTH_DFLT - 1), '0);
        offer(OP_SET,   INDEX_W'(7),              $urandom);
        offer(OP_GET,   INDEX_W'(7),              '0);
        offer(OP_GET,   INDEX_W'(5),              '0);
        offer(OP_CLEAR, '0,                       '0);
        offer(OP_GET,   INDEX_W'(7),              '0);
        drain();

        // Random segments, each under its own default value
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       dflt = '0;
                1:       dflt = '1;
                3:       dflt = 32'h8000_0001;
                default: dflt = $urandom;
            endcase
            write_default(dflt);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                // Hold off the result side while operations keep coming
                if ((seg == 1 && n == 60) || (seg == 3 && n == 150)) begin
                    hold_req = 1'b1;
                end
                pick_random(op, idx, val);
                offer(op, idx, val);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("generation_tagged_array_tb OK");
        end else begin
            $display("generation_tagged_array_tb NOT OK");
        end
        $finish;
    end

endmodule
